FILE: hw/rtl/priority_message_queue_defines.svh
// Assertion macros for the priority message queue.
// Used by hw/rtl/priority_message_queue.sv; no other dependencies.
`ifndef PRIORITY_MESSAGE_QUEUE_DEFINES_SVH
`define PRIORITY_MESSAGE_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define PMQ_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define PMQ_ASSERT_IMPL(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
`else
`define PMQ_ASSERT(label, expr, msg)
`define PMQ_ASSERT_IMPL(label, cond, expr, msg)
`endif
`endif

FILE: hw/rtl/pmq_pkg.sv
// Shared types, codes and helpers of the priority message queue.
// No dependencies.
package pmq_pkg;
    localparam int CAPACITY     = 64;
    localparam int PRIO_LEVELS  = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = 6;   // slot index width
    localparam int PRIO_W       = 5;   // stored priority width
    localparam int LEN_W        = 21;
    localparam int CNT_W        = 7;

    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_PRIO = 2'd1;
    localparam logic [1:0] ST_SIZE     = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [2:0] ADDR_MAX_MESSAGES = 3'd0;
    localparam logic [2:0] ADDR_MAX_SIZE     = 3'd4;

    typedef struct packed {
        logic        command;
        logic [5:0]  priority_req;
        logic [31:0] payload;
        logic [20:0] length;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_payload;
        logic [20:0] out_length;
        logic [4:0]  out_priority;
        logic [6:0]  occupancy;
    } rsp_t;

    // highest set bit of the nonempty mask
    function automatic logic [PRIO_W-1:0] top_prio(input logic [PRIO_LEVELS-1:0] mask);
        logic [PRIO_W-1:0] r;
        r = '0;
        for (int i = 0; i < PRIO_LEVELS; i++)
        begin
            if (mask[i])
            begin
                r = PRIO_W'(i);
            end
        end
        return r;
    endfunction
endpackage

FILE: hw/rtl/pmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: hw/rtl/priority_message_queue.sv
// Top level of the priority message queue: control, per-priority lists, APB registers.
// Depends on pmq_pkg, pmq_ram and priority_message_queue_defines.svh.
//
// Usage:
//  - req channel (req_valid/req_ready, req): one beat is one send or receive call.
//  - rsp channel (rsp_valid/rsp_ready, rsp): exactly one result beat per request beat,
//    in order: status, received message fields (zero unless a receive succeeds) and
//    the occupancy after the call.
//  - APB port: register 0 max_messages at 0x0, register 1 max_message_size at 0x4.
//    Write only while idle.
// Flow: a request is accepted only in S_IDLE and moves to S_EXEC, where the list
// update is done and the result beat is registered into the output register. The
// link and data RAMs are read on acceptance, with registered read data, for S_EXEC.
// The next request is taken while the previous result still waits in the output
// register; the update stalls only if that register is still full.
// Reset: queue empty, max_messages 64, max_message_size 65536. RAM contents are
// never used before written, so there is no clearing pass.
// Storage: messages live in one linked list per priority inside a data RAM
// (length, payload) and a link RAM (next index). Freed slots form a free list
// through the link RAM; never-used slots are handed out by a fill counter.
// Head is the highest nonempty priority; a list is FIFO, so equal priorities
// leave oldest first.
module priority_message_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  pmq_pkg::req_t      req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pmq_pkg::rsp_t      rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pmq_pkg::*;
    `include "priority_message_queue_defines.svh"

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    localparam int DATA_W = LEN_W + PAYLOAD_BITS;

    state_t                 state_reg;
    req_t                   op_reg;
    logic [1:0]             stat_reg;
    logic [PRIO_W-1:0]      top_reg;
    logic                   use_free_reg;
    logic [IDX_W-1:0]       head_reg [PRIO_LEVELS];
    logic [IDX_W-1:0]       tail_reg [PRIO_LEVELS];
    logic [PRIO_LEVELS-1:0] nonempty_reg;
    logic [IDX_W-1:0]       free_head_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       max_msg_reg;
    logic [LEN_W-1:0]       max_size_reg;
    rsp_t                   rsp_reg;
    logic                   rsp_valid_reg;

    logic                   accept;
    logic                   exec_go;
    logic                   exec_send;
    logic [CNT_W-1:0]       limit;
    logic [1:0]             stat_in;
    logic [PRIO_W-1:0]      top_now;
    logic                   cfg_wr;

    logic                   link_we, data_we;
    logic [IDX_W-1:0]       link_waddr, link_raddr, data_waddr;
    logic [IDX_W-1:0]       link_wdata, link_rdata;
    logic [DATA_W-1:0]      data_wdata, data_rdata;

    logic [PRIO_W-1:0]      snd_p;
    logic [IDX_W-1:0]       snd_slot;
    logic [IDX_W-1:0]       rcv_slot;
    logic                   ok;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign exec_go   = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;

    assign limit   = (max_msg_reg > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : max_msg_reg;
    assign top_now = top_prio(nonempty_reg);

    // status of the incoming call, checked in the documented order
    always_comb
    begin
        stat_in = ST_OK;
        if (req.command == CMD_SEND)
        begin
            priority if (req.priority_req >= 6'(PRIO_LEVELS)) stat_in = ST_BAD_PRIO;
            else if (req.length > max_size_reg)               stat_in = ST_SIZE;
            else if (count_reg >= limit)                      stat_in = ST_FULL;
            else                                              stat_in = ST_OK;
        end
        else
        begin
            priority if (req.length < max_size_reg) stat_in = ST_SIZE;
            else if (count_reg == '0)               stat_in = ST_FULL;
            else                                    stat_in = ST_OK;
        end
    end

    // free list is nonempty when some used slot has been released
    assign link_raddr = (req.command == CMD_SEND) ? free_head_reg : head_reg[top_now];

    assign ok        = (stat_reg == ST_OK);
    assign exec_send = exec_go && ok && (op_reg.command == CMD_SEND);
    assign snd_p     = op_reg.priority_req[PRIO_W-1:0];
    assign snd_slot  = use_free_reg ? free_head_reg : fill_reg[IDX_W-1:0];
    assign rcv_slot  = head_reg[top_reg];

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = rcv_slot;
        link_wdata = free_head_reg;
        data_we    = 1'b0;
        data_waddr = snd_slot;
        data_wdata = {op_reg.length, op_reg.payload};
        if (exec_go && ok)
        begin
            if (op_reg.command == CMD_SEND)
            begin
                data_we    = 1'b1;
                link_we    = nonempty_reg[snd_p];
                link_waddr = tail_reg[snd_p];
                link_wdata = snd_slot;
            end
            else
            begin
                link_we = 1'b1;
            end
        end
    end

    pmq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (accept),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    pmq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (accept),
        .raddr (head_reg[top_now]),
        .rdata (data_rdata)
    );

    always_comb
    begin
        unique case (paddr)
            ADDR_MAX_MESSAGES: prdata = 32'(max_msg_reg);
            ADDR_MAX_SIZE:     prdata = 32'(max_size_reg);
            default:           prdata = '0;
        endcase
    end

    // registers without reset: request, response and list pointers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= req;
            stat_reg     <= stat_in;
            top_reg      <= top_now;
            use_free_reg <= (fill_reg != count_reg);
        end
        if (exec_go)
        begin
            rsp_reg.status       <= stat_reg;
            rsp_reg.out_payload  <= '0;
            rsp_reg.out_length   <= '0;
            rsp_reg.out_priority <= '0;
            rsp_reg.occupancy    <= count_reg;
            if (ok)
            begin
                if (op_reg.command == CMD_SEND)
                begin
                    rsp_reg.occupancy <= count_reg + 1'b1;
                    if (!nonempty_reg[snd_p])
                    begin
                        head_reg[snd_p] <= snd_slot;
                    end
                    tail_reg[snd_p] <= snd_slot;
                end
                else
                begin
                    rsp_reg.out_payload  <= data_rdata[PAYLOAD_BITS-1:0];
                    rsp_reg.out_length   <= data_rdata[DATA_W-1:PAYLOAD_BITS];
                    rsp_reg.out_priority <= top_reg;
                    rsp_reg.occupancy    <= count_reg - 1'b1;
                    head_reg[top_reg]    <= link_rdata;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            nonempty_reg  <= '0;
            free_head_reg <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            max_msg_reg   <= CNT_W'(64);
            max_size_reg  <= LEN_W'(65536);
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                unique case (paddr)
                    ADDR_MAX_MESSAGES: max_msg_reg  <= pwdata[CNT_W-1:0];
                    ADDR_MAX_SIZE:     max_size_reg <= pwdata[LEN_W-1:0];
                    default:           ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (exec_go)
                    begin
                        state_reg     <= S_IDLE;
                        rsp_valid_reg <= 1'b1;
                        if (ok)
                        begin
                            if (op_reg.command == CMD_SEND)
                            begin
                                count_reg           <= count_reg + 1'b1;
                                nonempty_reg[snd_p] <= 1'b1;
                                if (use_free_reg)
                                begin
                                    free_head_reg <= link_rdata;
                                end
                                else
                                begin
                                    fill_reg <= fill_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                count_reg     <= count_reg - 1'b1;
                                free_head_reg <= rcv_slot;
                                if (tail_reg[top_reg] == rcv_slot)
                                begin
                                    nonempty_reg[top_reg] <= 1'b0;
                                end
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `PMQ_ASSERT(a_count_le_fill, count_reg <= fill_reg, "count above fill")
    `PMQ_ASSERT(a_fill_le_cap, fill_reg <= CNT_W'(CAPACITY), "fill above capacity")
    `PMQ_ASSERT(a_empty_lists, (count_reg == '0) == (nonempty_reg == '0), "list mask mismatch")
    `PMQ_ASSERT_IMPL(a_send_room, exec_send, count_reg < CNT_W'(CAPACITY), "send into full queue")
endmodule
